// ===== hdl/bfa_pkg.sv =====
package bfa_pkg;

    localparam int FieldW         = 14;
    localparam int WordBits       = 32;
    localparam int WordShift      = $clog2(WordBits);
    localparam int MapBitsDefault = 8192;
    localparam int CfgIndexW      = 2;

    localparam logic [FieldW-1:0] CfgResetValue = FieldW'(8192);

    typedef enum logic [CfgIndexW-1:0] {
        CFG_INODE_COUNT      = 2'd0,
        CFG_BLOCK_COUNT      = 2'd1,
        CFG_INIT_FREE_INODES = 2'd2,
        CFG_INIT_FREE_BLOCKS = 2'd3
    } t_cfg_index;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_command;

    typedef struct packed {
        logic              command;
        logic              map_select;
        logic [FieldW-1:0] entry_number;
    } t_cmd_beat;

    typedef struct packed {
        logic              success;
        logic [FieldW-1:0] result_number;
        logic [FieldW-1:0] free_inodes;
        logic [FieldW-1:0] free_blocks;
    } t_res_beat;

endpackage

// ===== hdl/bfa_map_ram.sv =====
module bfa_map_ram
    import bfa_pkg::*;
#(
    parameter int ADDR_W = $clog2(2 * MapBitsDefault / WordBits),
    parameter int DATA_W = WordBits
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bitmap_first_free_allocator_unit.sv =====
// channel   direction  handshake           beat
// command   in         i_valid / o_stall   i_cmd (t_cmd_beat)
// result    out        o_valid / i_stall   o_res (t_res_beat)
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// Allocate: scans the bitmap one word at a time, up to ceil(min(count, MAP_BITS) / 32) words;
// the single read port of the map RAM sets this pace.
// Free: reads one word, then writes it back with the bit cleared if it was set; out of range skips both.
// After reset a clearing pass writes every RAM word, 2 * 2**ceil(log2(MAP_BITS / 32)) words
// (512 at 8192 entries); no command beat is taken meanwhile.
// One command at a time; the next is taken while a result beat still waits on i_stall.
module bitmap_first_free_allocator_unit
    import bfa_pkg::*;
#(
    parameter int MAP_BITS = MapBitsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_cmd_beat            i_cmd,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_res_beat            o_res,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [FieldW-1:0]    i_cfg_data
);

    localparam int WordCount  = (MAP_BITS + WordBits - 1) / WordBits;
    localparam int WA         = (WordCount > 1) ? $clog2(WordCount) : 1;
    localparam int WCW        = $clog2(WordCount + 1);
    localparam int AW         = WA + 1;
    localparam int LW         = $clog2(MAP_BITS + 1);
    localparam int CW         = (LW > FieldW) ? LW : FieldW;
    localparam int PW         = WCW + WordShift;
    localparam int FieldMax   = (1 << FieldW) - 1;
    localparam int CounterCap = (MAP_BITS > FieldMax) ? FieldMax : MAP_BITS;
    localparam logic [FieldW-1:0] CapValue     = FieldW'(CounterCap);
    localparam logic [FieldW-1:0] CounterReset =
        (CfgResetValue > CapValue) ? CapValue : CfgResetValue;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_CHK,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic                r_sel;
    logic [WCW-1:0]      r_word;
    logic [WordShift-1:0] r_bit;
    logic [LW-1:0]       r_limit;
    logic [FieldW-1:0]   r_entry;
    logic                r_success;
    logic [FieldW-1:0]   r_result;
    logic [FieldW-1:0]   r_inode_count;
    logic [FieldW-1:0]   r_block_count;
    logic [FieldW-1:0]   r_free_inodes;
    logic [FieldW-1:0]   r_free_blocks;
    logic                r_out_valid;
    t_res_beat           r_out;

    logic [FieldW-1:0]    pos_m1;
    logic                 entry_ok;
    logic [FieldW-1:0]    sel_count;
    logic [LW-1:0]        start_limit;
    logic [WCW-1:0]       free_word;
    logic [WCW-1:0]       word_next;
    logic [PW-1:0]        base_full;
    logic [LW-1:0]        rem;
    logic                 last_word;
    logic [WordBits-1:0]  vmask;
    logic [WordBits-1:0]  masked;
    logic [WordBits-1:0]  rd_data;
    logic                 hit;
    logic [WordShift-1:0] hit_idx;
    logic [PW:0]          alloc_pos1;
    logic [WordBits-1:0]  set_word;
    logic [WordBits-1:0]  clr_word;
    logic                 bit_set;
    logic [FieldW-1:0]    ctr_sel;
    logic [FieldW-1:0]    ctr_dec;
    logic [FieldW-1:0]    ctr_inc;
    logic [FieldW-1:0]    cfg_clamped;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WordBits-1:0]  mem_wdata;
    logic [AW-1:0]        mem_raddr;

    assign pos_m1      = i_cmd.entry_number - FieldW'(1);
    assign entry_ok    = (i_cmd.entry_number != '0) &&
                         (CW'(i_cmd.entry_number) <= CW'(MAP_BITS));
    assign sel_count   = i_cmd.map_select ? r_block_count : r_inode_count;
    assign start_limit = (CW'(sel_count) > CW'(MAP_BITS)) ? LW'(MAP_BITS) : LW'(sel_count);
    assign free_word   = WCW'(pos_m1 >> WordShift);
    assign word_next   = r_word + WCW'(1);
    assign base_full   = {r_word, {WordShift{1'b0}}};
    assign rem         = r_limit - LW'(base_full);
    assign last_word   = (rem <= LW'(WordBits));

    always_comb begin
        for (int j = 0; j < WordBits; j++) begin
            vmask[j] = (LW'(j) < rem);
        end
    end

    assign masked = rd_data | ~vmask;

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = WordBits - 1; j >= 0; j--) begin
            if (!masked[j]) begin
                hit     = 1'b1;
                hit_idx = WordShift'(j);
            end
        end
    end

    assign alloc_pos1  = (PW + 1)'({r_word, hit_idx}) + (PW + 1)'(1);
    assign set_word    = rd_data | (WordBits'(1) << hit_idx);
    assign clr_word    = rd_data & ~(WordBits'(1) << r_bit);
    assign bit_set     = rd_data[r_bit];
    assign ctr_sel     = r_sel ? r_free_blocks : r_free_inodes;
    assign ctr_dec     = (ctr_sel != '0) ? ctr_sel - FieldW'(1) : ctr_sel;
    assign ctr_inc     = (ctr_sel < CapValue) ? ctr_sel + FieldW'(1) : ctr_sel;
    assign cfg_clamped = (i_cfg_data > CapValue) ? CapValue : i_cfg_data;

    always_comb begin
        mem_raddr = {r_sel, r_word[WA-1:0]};
        mem_we    = 1'b0;
        mem_waddr = {r_sel, r_word[WA-1:0]};
        mem_wdata = set_word;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                mem_raddr = {i_cmd.map_select,
                             (i_cmd.command == CMD_FREE) ? free_word[WA-1:0] : WA'(0)};
            end
            S_SCAN: begin
                mem_raddr = {r_sel, word_next[WA-1:0]};
                mem_we    = hit;
            end
            S_FREE_CHK: begin
                mem_we    = bit_set;
                mem_wdata = clr_word;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    bfa_map_ram #(
        .ADDR_W (AW),
        .DATA_W (WordBits)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
            r_inode_count <= CfgResetValue;
            r_block_count <= CfgResetValue;
            r_free_inodes <= CounterReset;
            r_free_blocks <= CounterReset;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_INODE_COUNT:      r_inode_count <= i_cfg_data;
                    CFG_BLOCK_COUNT:      r_block_count <= i_cfg_data;
                    CFG_INIT_FREE_INODES: r_free_inodes <= cfg_clamped;
                    CFG_INIT_FREE_BLOCKS: r_free_blocks <= cfg_clamped;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_sel     <= i_cmd.map_select;
                        r_entry   <= i_cmd.entry_number;
                        r_bit     <= pos_m1[WordShift-1:0];
                        r_limit   <= start_limit;
                        r_success <= 1'b0;
                        r_result  <= '0;
                        if (i_cmd.command == CMD_FREE) begin
                            r_word  <= free_word;
                            r_state <= entry_ok ? S_FREE_CHK : S_DONE;
                        end else begin
                            r_word  <= '0;
                            r_state <= (start_limit != '0) ? S_SCAN : S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        if (r_sel) begin
                            r_free_blocks <= ctr_dec;
                        end else begin
                            r_free_inodes <= ctr_dec;
                        end
                        r_success <= 1'b1;
                        r_result  <= FieldW'(alloc_pos1);
                        r_state   <= S_DONE;
                    end else if (last_word) begin
                        r_state <= S_DONE;
                    end else begin
                        r_word <= word_next;
                    end
                end
                S_FREE_CHK: begin
                    if (bit_set) begin
                        if (r_sel) begin
                            r_free_blocks <= ctr_inc;
                        end else begin
                            r_free_inodes <= ctr_inc;
                        end
                        r_success <= 1'b1;
                        r_result  <= r_entry;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid         <= 1'b1;
                        r_out.success       <= r_success;
                        r_out.result_number <= r_result;
                        r_out.free_inodes   <= r_free_inodes;
                        r_out.free_blocks   <= r_free_blocks;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_counter_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_inodes <= CapValue) && (r_free_blocks <= CapValue))
        else $error("free counter above map size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("command beat taken while a command is in progress");

    a_success_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.success == (o_res.result_number != '0)))
        else $error("success flag disagrees with result number");

    a_scan_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (base_full < PW'(r_limit)))
        else $error("scan word beyond search limit");
`endif

endmodule

// ===== sim/bitmap_first_free_allocator_unit_checker.sv =====
module bitmap_first_free_allocator_unit_checker
    import bfa_pkg::*;
#(
    parameter int MAP_BITS = MapBitsDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  logic                 i_cmd_stall,
    input  t_cmd_beat            i_cmd,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  t_res_beat            i_res,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [FieldW-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int CounterCap = (MAP_BITS > 16383) ? 16383 : MAP_BITS;

    bit                inode_used [MAP_BITS];
    bit                block_used [MAP_BITS];
    logic [FieldW-1:0] inode_count;
    logic [FieldW-1:0] block_count;
    logic [FieldW-1:0] free_inodes;
    logic [FieldW-1:0] free_blocks;
    t_res_beat         expected_results [$];
    t_res_beat         oldest;
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [FieldW-1:0] clamp_to_cap(input logic [FieldW-1:0] v);
        return (v > CounterCap) ? FieldW'(CounterCap) : v;
    endfunction

    // Run one command against the shadow maps and return the beat it should produce.
    function automatic t_res_beat allocation_outcome(input t_cmd_beat c);
        t_res_beat r;
        int        limit;
        int        pos;
        bit        taken;
        r = '0;
        if (c.command == CMD_ALLOC) begin
            limit = c.map_select ? int'(block_count) : int'(inode_count);
            if (limit > MAP_BITS) limit = MAP_BITS;
            for (pos = 0; pos < limit; pos++) begin
                taken = c.map_select ? block_used[pos] : inode_used[pos];
                if (!taken) break;
            end
            if (pos < limit) begin
                if (c.map_select) begin
                    block_used[pos] = 1'b1;
                    if (free_blocks > 0) free_blocks = free_blocks - 1'b1;
                end else begin
                    inode_used[pos] = 1'b1;
                    if (free_inodes > 0) free_inodes = free_inodes - 1'b1;
                end
                r.success       = 1'b1;
                r.result_number = FieldW'(pos + 1);
            end
        end else if (c.entry_number >= 1 && int'(c.entry_number) <= MAP_BITS) begin
            pos   = int'(c.entry_number) - 1;
            taken = c.map_select ? block_used[pos] : inode_used[pos];
            if (taken) begin
                if (c.map_select) begin
                    block_used[pos] = 1'b0;
                    if (free_blocks < CounterCap) free_blocks = free_blocks + 1'b1;
                end else begin
                    inode_used[pos] = 1'b0;
                    if (free_inodes < CounterCap) free_inodes = free_inodes + 1'b1;
                end
                r.success       = 1'b1;
                r.result_number = c.entry_number;
            end
        end
        r.free_inodes = free_inodes;
        r.free_blocks = free_blocks;
        return r;
    endfunction

    task automatic note_failure(input string what, input t_res_beat want, input t_res_beat got);
        if (fail_count < 10) begin
            $display("%s: expected ok=%0b num=%0d fi=%0d fb=%0d, got ok=%0b num=%0d fi=%0d fb=%0d",
                     what, want.success, want.result_number, want.free_inodes,
                     want.free_blocks, got.success, got.result_number, got.free_inodes,
                     got.free_blocks);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (inode_used[k]) inode_used[k] = 1'b0;
            foreach (block_used[k]) block_used[k] = 1'b0;
            inode_count = CfgResetValue;
            block_count = CfgResetValue;
            free_inodes = clamp_to_cap(CfgResetValue);
            free_blocks = clamp_to_cap(CfgResetValue);
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_INODE_COUNT:      inode_count = i_cfg_data;
                    CFG_BLOCK_COUNT:      block_count = i_cfg_data;
                    CFG_INIT_FREE_INODES: free_inodes = clamp_to_cap(i_cfg_data);
                    CFG_INIT_FREE_BLOCKS: free_blocks = clamp_to_cap(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                expected_results.push_back(allocation_outcome(i_cmd));
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    note_failure("unexpected result beat", '0, i_res);
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_res.success !== oldest.success ||
                        i_res.result_number !== oldest.result_number ||
                        i_res.free_inodes !== oldest.free_inodes ||
                        i_res.free_blocks !== oldest.free_blocks) begin
                        note_failure("result mismatch", oldest, i_res);
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== sim/bitmap_first_free_allocator_unit_test.sv =====
module bitmap_first_free_allocator_unit_test;
    import bfa_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_cmd_beat            i_cmd;
    logic                 o_valid;
    logic                 i_stall;
    t_res_beat            o_res;
    logic                 i_cfg_we;
    logic [CfgIndexW-1:0] i_cfg_index;
    logic [FieldW-1:0]    i_cfg_data;

    int fail_count;
    int pending;
    int stall_left;
    bit long_hold_req;
    bit idle_enable;
    int inode_limit;
    int block_limit;

    bitmap_first_free_allocator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bitmap_first_free_allocator_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_stall  (o_stall),
        .i_cmd        (i_cmd),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("bitmap_first_free_allocator_unit_test NOT OK");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold on request.
    initial begin
        i_stall    = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = 400;
            end else if (idle_enable && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            i_stall <= (stall_left != 0);
        end
    end

    task automatic push_cmd(input t_command cmd, input logic sel, input logic [FieldW-1:0] entry);
        t_cmd_beat beat;
        beat.command      = cmd;
        beat.map_select   = sel;
        beat.entry_number = entry;
        i_valid <= 1'b1;
        i_cmd   <= beat;
        do @(posedge i_clk); while (o_stall);
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Drop valid, then wait for every outstanding beat to drain.
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [FieldW-1:0] ic, input logic [FieldW-1:0] bc,
                                input logic [FieldW-1:0] fi, input logic [FieldW-1:0] fb);
        inode_limit = int'(ic);
        block_limit = int'(bc);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_INODE_COUNT;
        i_cfg_data  <= ic;
        @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK_COUNT;
        i_cfg_data  <= bc;
        @(posedge i_clk);
        i_cfg_index <= CFG_INIT_FREE_INODES;
        i_cfg_data  <= fi;
        @(posedge i_clk);
        i_cfg_index <= CFG_INIT_FREE_BLOCKS;
        i_cfg_data  <= fb;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int                lim;
        int                pick;
        logic [FieldW-1:0] ic;
        logic [FieldW-1:0] bc;
        logic [FieldW-1:0] fi;
        logic [FieldW-1:0] fb;
        logic [FieldW-1:0] entry;
        logic              sel;
        t_command          cmd;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cmd         = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_INODE_COUNT;
        i_cfg_data    = '0;
        long_hold_req = 1'b0;
        idle_enable   = 1'b1;
        inode_limit   = int'(CfgResetValue);
        block_limit   = int'(CfgResetValue);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: basic allocate and free, bad entries, double free
        push_cmd(CMD_ALLOC, 1'b0, '0);
        push_cmd(CMD_ALLOC, 1'b1, '0);
        push_cmd(CMD_FREE,  1'b0, FieldW'(1));
        push_cmd(CMD_FREE,  1'b0, FieldW'(1));
        push_cmd(CMD_FREE,  1'b1, FieldW'(0));
        push_cmd(CMD_FREE,  1'b1, FieldW'(8193));
        push_cmd(CMD_FREE,  1'b1, FieldW'(16383));
        push_cmd(CMD_FREE,  1'b0, FieldW'(8192));
        push_cmd(CMD_ALLOC, 1'b0, FieldW'(16383));
        push_cmd(CMD_FREE,  1'b1, FieldW'(1));
        push_cmd(CMD_FREE,  1'b1, FieldW'(1));
        drain();

        // zero count, tiny map filling up, presets at both ends
        write_config(FieldW'(0), FieldW'(3), FieldW'(0), FieldW'(16383));
        push_cmd(CMD_ALLOC, 1'b0, '0);
        push_cmd(CMD_ALLOC, 1'b1, '0);
        push_cmd(CMD_ALLOC, 1'b1, '0);
        push_cmd(CMD_ALLOC, 1'b1, '0);
        push_cmd(CMD_ALLOC, 1'b1, '0);
        push_cmd(CMD_FREE,  1'b0, FieldW'(1));
        push_cmd(CMD_ALLOC, 1'b0, '0);
        drain();

        // count beyond the map, free above the count, counter at its ceiling
        write_config(FieldW'(16383), FieldW'(1), FieldW'(8192), FieldW'(8192));
        push_cmd(CMD_FREE,  1'b1, FieldW'(3));
        push_cmd(CMD_ALLOC, 1'b0, '0);
        push_cmd(CMD_ALLOC, 1'b1, '0);
        drain();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin
                    ic = FieldW'(8192);
                    bc = FieldW'(8192);
                    fi = FieldW'(16383);
                    fb = FieldW'(0);
                end
                1: begin
                    ic = FieldW'(1);
                    bc = FieldW'(1);
                    fi = FieldW'(0);
                    fb = FieldW'(8192);
                end
                2: begin
                    ic = FieldW'(16383);
                    bc = FieldW'(0);
                    fi = FieldW'($urandom_range(0, 16383));
                    fb = FieldW'($urandom_range(0, 16383));
                end
                default: begin
                    ic = FieldW'(($urandom_range(0, 4) == 0) ? $urandom_range(65, 600)
                                                            : $urandom_range(1, 64));
                    bc = FieldW'(($urandom_range(0, 4) == 0) ? $urandom_range(65, 600)
                                                            : $urandom_range(1, 64));
                    fi = FieldW'($urandom_range(0, 16383));
                    fb = FieldW'($urandom_range(0, 16383));
                end
            endcase
            idle_enable = (p != 5 && p != 9);
            write_config(ic, bc, fi, fb);
            for (int n = 0; n < 118; n++) begin
                if (p == 3 && n == 20) long_hold_req = 1'b1;
                cmd = t_command'($urandom_range(0, 1));
                sel = 1'($urandom_range(0, 1));
                if (cmd == CMD_ALLOC) begin
                    entry = FieldW'($urandom_range(0, 16383));
                end else begin
                    lim = sel ? block_limit : inode_limit;
                    if (lim < 1) lim = 1;
                    if (lim > MapBitsDefault) lim = MapBitsDefault;
                    pick = $urandom_range(0, 19);
                    if (pick < 15) entry = FieldW'($urandom_range(1, lim + 2));
                    else if (pick < 17) entry = '0;
                    else entry = FieldW'($urandom_range(0, 16383));
                end
                push_cmd(cmd, sel, entry);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bitmap_first_free_allocator_unit_test OK");
        end else begin
            $display("bitmap_first_free_allocator_unit_test NOT OK");
        end
        $finish;
    end

endmodule
